// ----- rtl/hsl_to_rgb888_converter_macros.svh -----
// ----------------------------------------------------------------------------
// HSL to RGB888 converter assertion macros
// Shared wrappers for the concurrent checks of the converter pipeline.
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB888_CONVERTER_MACROS_SVH
`define HSL_TO_RGB888_CONVERTER_MACROS_SVH

// Checks a property at every clock edge outside of reset.
`define HSLC_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next.
`define HSLC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/hslc_pkg.sv -----
// ----------------------------------------------------------------------------
// HSL to RGB888 converter package
// Fixed-point constants, beat payload types and pipeline control types.
// ----------------------------------------------------------------------------
package hslc_pkg;

   // Fixed-point format: FRAC_BITS fraction bits, one extra bit to hold 1.0.
   localparam int FRAC_BITS = 16;
   localparam int HUE_W     = FRAC_BITS;
   localparam int FX_W      = FRAC_BITS + 1;
   localparam int CH_W      = 8;

   // Constants in fixed point, truncated.
   localparam logic [FX_W-1:0] ONE_FX        = FX_W'(1 << FRAC_BITS);
   localparam logic [FX_W-1:0] THIRD_FX      = FX_W'((1 << FRAC_BITS) / 3);
   localparam logic [FX_W-1:0] SIXTH_FX      = FX_W'((1 << FRAC_BITS) / 6);
   localparam logic [FX_W-1:0] HALF_FX       = FX_W'((1 << FRAC_BITS) / 2);
   localparam logic [FX_W-1:0] TWO_THIRDS_FX = FX_W'((2 * (1 << FRAC_BITS)) / 3);

   // Input beat.
   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [FX_W-1:0]  saturation;
      logic [FX_W-1:0]  lightness;
   } req_payload_type;

   // Result beat.
   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } rsp_payload_type;

   // Stage one result: clamped inputs, their product and the hue weights.
   typedef struct packed {
      logic [FX_W-1:0] light;
      logic [FX_W-1:0] sat;
      logic [FX_W-1:0] light_sat;
      logic [FX_W-1:0] weight_r;
      logic [FX_W-1:0] weight_g;
      logic [FX_W-1:0] weight_b;
   } front_type;

   // Stage two result: floor p, span q - p and the hue weights.
   typedef struct packed {
      logic [FX_W-1:0] p;
      logic [FX_W-1:0] d;
      logic [FX_W-1:0] weight_r;
      logic [FX_W-1:0] weight_g;
      logic [FX_W-1:0] weight_b;
   } chroma_type;

   // Load enables of the two channel stages.
   typedef struct packed {
      logic load_prod;
      logic load_byte;
   } ch_ctrl_type;

endpackage

// ----- rtl/hslc_front.sv -----
// ----------------------------------------------------------------------------
// HSL converter front stage
// Clamps saturation and lightness, multiplies them and turns each channel's
// shifted hue into a ramp weight.
// ----------------------------------------------------------------------------
module hslc_front
   import hslc_pkg::*;
(
   input  logic            clock,
   input  logic            load,
   input  req_payload_type req_payload,
   output front_type       front_ff
);

   // Ramp weight at hue position t: 6t on the rising edge, 1.0 on the top,
   // 6(2/3 - t) on the falling edge and zero elsewhere.
   function automatic logic [FX_W-1:0] ramp_weight(input logic [FX_W-1:0] t);
      logic [FX_W-1:0] x;
      x = TWO_THIRDS_FX - t;
      priority if (t < SIXTH_FX) begin
         ramp_weight = (t << 2) + (t << 1);
      end else if (t < HALF_FX) begin
         ramp_weight = ONE_FX;
      end else if (t < TWO_THIRDS_FX) begin
         ramp_weight = (x << 2) + (x << 1);
      end else begin
         ramp_weight = '0;
      end
   endfunction

   logic [FX_W-1:0]   sat_c;
   logic [FX_W-1:0]   light_c;
   logic [2*FX_W-1:0] product;
   logic [FX_W-1:0]   hue_x;
   logic [FX_W-1:0]   t_red;
   logic [FX_W-1:0]   t_blue;
   front_type         front_in;

   // Values above 1.0 saturate at 1.0.
   assign sat_c   = (req_payload.saturation > ONE_FX) ? ONE_FX : req_payload.saturation;
   assign light_c = (req_payload.lightness > ONE_FX) ? ONE_FX : req_payload.lightness;
   assign product = light_c * sat_c;

   // Hue shifted by a third of a turn either way, wrapped once into range.
   always_comb begin
      hue_x = {1'b0, req_payload.hue};
      t_red = hue_x + THIRD_FX;
      if (t_red > ONE_FX) begin
         t_red = t_red - ONE_FX;
      end
      if (hue_x < THIRD_FX) begin
         t_blue = hue_x + (ONE_FX - THIRD_FX);
      end else begin
         t_blue = hue_x - THIRD_FX;
      end
   end

   always_comb begin
      front_in.light     = light_c;
      front_in.sat       = sat_c;
      front_in.light_sat = product[FRAC_BITS +: FX_W];
      front_in.weight_r  = ramp_weight(t_red);
      front_in.weight_g  = ramp_weight(hue_x);
      front_in.weight_b  = ramp_weight(t_blue);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         front_ff <= front_in;
      end
   end

endmodule

// ----- rtl/hslc_chroma.sv -----
// ----------------------------------------------------------------------------
// HSL converter chroma stage
// Forms q and p from lightness and saturation and passes on p and q - p.
// ----------------------------------------------------------------------------
module hslc_chroma
   import hslc_pkg::*;
(
   input  logic       clock,
   input  logic       load,
   input  front_type  front_ff,
   output chroma_type chroma_ff
);

   logic [FX_W:0]   sum_hi;
   logic [FX_W:0]   sum_lo;
   logic [FX_W-1:0] q;
   logic [FX_W:0]   twice_l;
   logic [FX_W-1:0] p;
   chroma_type      chroma_in;

   // q = l(1 + s) below half lightness, l + s - ls above; both stay within 1.0.
   always_comb begin
      sum_lo  = {1'b0, front_ff.light} + {1'b0, front_ff.light_sat};
      sum_hi  = {1'b0, front_ff.light} + {1'b0, front_ff.sat} - {1'b0, front_ff.light_sat};
      q       = (front_ff.light < HALF_FX) ? sum_lo[FX_W-1:0] : sum_hi[FX_W-1:0];
      twice_l = {front_ff.light, 1'b0};
   end

   // p = 2l - q, held at zero should truncation push it below.
   always_comb begin
      if ({1'b0, q} > twice_l) begin
         p = '0;
      end else begin
         p = twice_l[FX_W-1:0] - q;
      end
   end

   always_comb begin
      chroma_in.p        = p;
      chroma_in.d        = q - p;
      chroma_in.weight_r = front_ff.weight_r;
      chroma_in.weight_g = front_ff.weight_g;
      chroma_in.weight_b = front_ff.weight_b;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         chroma_ff <= chroma_in;
      end
   end

endmodule

// ----- rtl/hslc_channel.sv -----
// ----------------------------------------------------------------------------
// HSL converter color channel
// Scales the span by the ramp weight, adds the floor and maps the result
// to an 8-bit code, over two register stages.
// ----------------------------------------------------------------------------
module hslc_channel
   import hslc_pkg::*;
(
   input  logic            clock,
   input  ch_ctrl_type     ctrl,
   input  logic [FX_W-1:0] p,
   input  logic [FX_W-1:0] d,
   input  logic [FX_W-1:0] weight,
   output logic [CH_W-1:0] byte_ff
);

   localparam int PROD_W   = 2 * FX_W;
   localparam int HI_W     = PROD_W - FRAC_BITS;
   localparam int VAL_W    = HI_W + 1;
   localparam int SCALED_W = VAL_W + CH_W;
   localparam int TOP_W    = SCALED_W - FRAC_BITS;

   logic [PROD_W-1:0]   product;
   logic [HI_W-1:0]     prod_hi_ff;
   logic [HI_W-1:0]     prod_hi_in;
   logic [FX_W-1:0]     p_ff;
   logic [VAL_W-1:0]    value;
   logic [SCALED_W-1:0] scaled;
   logic [TOP_W-1:0]    code;
   logic [CH_W-1:0]     byte_in;

   // Ramp offset above p: span times weight, back to the fixed-point scale.
   assign product    = d * weight;
   assign prod_hi_in = product[PROD_W-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (ctrl.load_prod) begin
         prod_hi_ff <= prod_hi_in;
         p_ff       <= p;
      end
   end

   // Channel value times 255, truncated and held at full scale.
   always_comb begin
      value   = {1'b0, prod_hi_ff} + VAL_W'(p_ff);
      scaled  = {value, {CH_W{1'b0}}} - SCALED_W'(value);
      code    = scaled[SCALED_W-1:FRAC_BITS];
      byte_in = (code > TOP_W'({CH_W{1'b1}})) ? {CH_W{1'b1}} : code[CH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_byte) begin
         byte_ff <= byte_in;
      end
   end

endmodule

// ----- rtl/hsl_to_rgb888_converter.sv -----
// ----------------------------------------------------------------------------
// HSL to RGB888 converter
// Four-stage pipeline from Q0.16 hue and Q1.16 saturation and lightness to 8-bit RGB.
// ----------------------------------------------------------------------------
// The converter takes one color per clock while no stall holds it and
// returns its RGB888 beat through four register stages: input clamping
// with the lightness-saturation product and hue weights, the q and p
// terms, the per-channel weight multiply, and the final scaling by 255 in
// the output register. A stall on the result side freezes only the stages
// that are full; empty stages keep filling, so bubbles close up and the
// input side stalls only when every stage holds a beat.
`include "hsl_to_rgb888_converter_macros.svh"

module hsl_to_rgb888_converter
   import hslc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic        s1_valid_ff, s1_valid_in;
   logic        s2_valid_ff, s2_valid_in;
   logic        s3_valid_ff, s3_valid_in;
   logic        s4_valid_ff, s4_valid_in;
   logic        load_1, load_2, load_3, load_4;
   ch_ctrl_type ch_ctrl;
   front_type   front_ff;
   chroma_type  chroma_ff;
   logic [FX_W:0] q_sum;

   // A stage loads when it is empty or its content moves on.
   always_comb begin
      load_4 = !s4_valid_ff || !rsp_stall;
      load_3 = !s3_valid_ff || load_4;
      load_2 = !s2_valid_ff || load_3;
      load_1 = !s1_valid_ff || load_2;
      ch_ctrl.load_prod = load_3;
      ch_ctrl.load_byte = load_4;
   end

   // Valid bits follow the data through the stages.
   always_comb begin
      s1_valid_in = load_1 ? req_valid   : s1_valid_ff;
      s2_valid_in = load_2 ? s1_valid_ff : s2_valid_ff;
      s3_valid_in = load_3 ? s2_valid_ff : s3_valid_ff;
      s4_valid_in = load_4 ? s3_valid_ff : s4_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   assign req_stall = !load_1;
   assign rsp_valid = s4_valid_ff;

   // Stage one: clamping, product and hue weights.
   hslc_front u_front (
      .clock       (clock),
      .load        (load_1),
      .req_payload (req_payload),
      .front_ff    (front_ff)
   );

   // Stage two: q and p.
   hslc_chroma u_chroma (
      .clock     (clock),
      .load      (load_2),
      .front_ff  (front_ff),
      .chroma_ff (chroma_ff)
   );

   // Stages three and four, one lane per color.
   hslc_channel u_red (
      .clock   (clock),
      .ctrl    (ch_ctrl),
      .p       (chroma_ff.p),
      .d       (chroma_ff.d),
      .weight  (chroma_ff.weight_r),
      .byte_ff (rsp_payload.red)
   );

   hslc_channel u_green (
      .clock   (clock),
      .ctrl    (ch_ctrl),
      .p       (chroma_ff.p),
      .d       (chroma_ff.d),
      .weight  (chroma_ff.weight_g),
      .byte_ff (rsp_payload.green)
   );

   hslc_channel u_blue (
      .clock   (clock),
      .ctrl    (ch_ctrl),
      .p       (chroma_ff.p),
      .d       (chroma_ff.d),
      .weight  (chroma_ff.weight_b),
      .byte_ff (rsp_payload.blue)
   );

   // The top of the ramp, q = p + d, never passes 1.0.
   assign q_sum = (FX_W+1)'(chroma_ff.p) + (FX_W+1)'(chroma_ff.d);

   `HSLC_ASSERT_NEXT(a_take_beat, req_valid && !req_stall, s1_valid_ff, "accepted beat not in stage one")
   `HSLC_ASSERT_CLK(a_q_range, s2_valid_ff |-> (q_sum <= (FX_W+1)'(ONE_FX)), "q above 1.0")
   `HSLC_ASSERT_CLK(a_full_stall, (s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_valid && rsp_stall) |-> req_stall, "full pipeline took a beat")
   `HSLC_ASSERT_NEXT(a_no_repeat, rsp_valid && !rsp_stall && !s3_valid_ff, !rsp_valid, "result beat repeated")

endmodule
